// ===== design/gsc_pkg.sv =====
// Shared constants for the grid segment collision checker.
`timescale 1ns / 1ps
`default_nettype none
package gsc_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int GRID_SIDE_DEF = 256;
  localparam int FRAC_BITS_DEF = 8;

  // Stream and configuration widths.
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd5;

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Result codes.
  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_OUT  = 2'd1;
  localparam logic [1:0] ST_HIT  = 2'd2;

  localparam logic signed [7:0] THRESH_RESET = 8'sd50;

endpackage : gsc_pkg
`default_nettype wire

// ===== design/grid_segment_collision_check.sv =====
// Top level of the occupancy grid segment collision checker.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  s_tdata request fields, s_tuser req_type
//  m_*       out        m_tvalid / m_tready  m_tdata status
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// A load word goes through accept, row read, row write back and result.
// A query word first runs its setup (squaring, square root, then seven
// divisions on one shared restoring divider), then walks its samples, each
// a bounds check with grid row read, then a bit test and step advance.
// After reset the grid is swept clear one row per cycle, during which no
// request word is taken; configuration writes are always taken.
// A result waits in the output register while the next word is accepted; the
// sequencer only stalls at its final step if that register is still full.
//
// The grid is kept as GRID_SIDE rows of GRID_SIDE bits in one synchronous
// memory. Sample positions and their cells are tracked incrementally: each
// step adds a precomputed quotient and remainder, so no per-sample division
// is needed.
module grid_segment_collision_check #(
  parameter int GRID_SIDE = gsc_pkg::GRID_SIDE_DEF,
  parameter int FRAC_BITS = gsc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // From bit 0: x_start[32], y_start[32], x_end[32], y_end[32],
  // cell_col[8], cell_row[8], occupancy[8].
  input  wire logic [gsc_pkg::IN_DATA_W-1:0]   s_tdata,
  // Bit 0: req_type.
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // From bit 0: status[2], then zero fill.
  output logic [gsc_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gsc_pkg::*;

  localparam int AW  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int GW  = 35;
  localparam int DW  = 36;
  localparam int CSW = 17;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LDRD = 4'd2;
  localparam logic [3:0] S_LDWR = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DLD  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DIVE = 4'd9;
  localparam logic [3:0] S_CHK  = 4'd10;
  localparam logic [3:0] S_TST  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  // Division jobs, run in this order.
  localparam logic [2:0] J_STEPS = 3'd0;
  localparam logic [2:0] J_QX    = 3'd1;
  localparam logic [2:0] J_QY    = 3'd2;
  localparam logic [2:0] J_QCX   = 3'd3;
  localparam logic [2:0] J_QCY   = 3'd4;
  localparam logic [2:0] J_UX    = 3'd5;
  localparam logic [2:0] J_UY    = 3'd6;

  logic [3:0] state;

  // Configuration registers.
  logic [8:0]              map_w, map_h;
  logic signed [31:0]      org [2];
  logic [CSW-1:0]          cell_size_r;
  logic signed [7:0]       thresh;
  logic [CSW-1:0]          cs;

  // Request registers.
  logic signed [31:0]      st [2];
  logic signed [32:0]      dd [2];
  logic [AW-1:0]           ld_row, ld_col;
  logic                    ld_bit;
  logic [1:0]              res;
  logic [1:0]              status_q;

  // Squaring, square root and divider.
  logic [5:0]              cnt;
  logic [32:0]             sqa [2];
  logic [65:0]             acc [2];
  logic [65:0]             sqv;
  logic [32:0]             root;
  logic [35:0]             srem;
  logic [2:0]              job;
  logic [DW-1:0]           div_q, div_d;
  logic [DW:0]             div_r;

  // Walk state.
  logic [DW-1:0]           n_steps;
  logic [DW-1:0]           idx;
  logic [32:0]             qv [2];
  logic [DW-1:0]           rv [2];
  logic [32:0]             qc [2];
  logic [CSW-1:0]          qm [2];
  logic signed [GW-1:0]    g [2];
  logic [CSW-1:0]          mr [2];
  logic [DW-1:0]           rr [2];
  logic [AW-1:0]           clr_addr;

  // Grid memory.
  logic [GRID_SIDE-1:0]    grid_mem [GRID_SIDE];
  logic [GRID_SIDE-1:0]    row_q;
  logic [GRID_SIDE-1:0]    mem_wd;
  logic [AW-1:0]           mem_wa, mem_ra;
  logic                    mem_we;

  // Combinational helpers.
  logic [32:0]             mag [2];
  logic signed [32:0]      u [2];
  logic [32:0]             umag [2];
  logic                    axis;
  logic [DW-1:0]           div_num, div_den;
  logic [DW:0]             div_sh;
  logic                    div_ge;
  logic [35:0]             rem_sh;
  logic [34:0]             trial;
  logic signed [GW-1:0]    lim_w, lim_h;
  logic                    out_of_map;
  logic [DW:0]             rsum [2];
  logic                    e_c [2];
  logic [DW-1:0]           rr_next [2];
  logic [CSW:0]            mt [2];
  logic                    mc [2];
  logic [CSW-1:0]          mr_next [2];
  logic signed [GW-1:0]    g_next [2];
  logic                    s_fire, m_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign m_free    = !m_tvalid || m_tready;
  assign m_tdata   = {{(OUT_DATA_W-2){1'b0}}, status_q};
  assign cs        = (cell_size_r == '0) ? CSW'(1) : cell_size_r;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mag[a]  = dd[a][32] ? 33'(-dd[a]) : 33'(dd[a]);
      u[a]    = {st[a][31], st[a]} - {org[a][31], org[a]};
      umag[a] = u[a][32] ? 33'(-u[a]) : 33'(u[a]);
    end
  end

  // Divider operands for the current job.
  always_comb begin
    axis = (job == J_QY) || (job == J_QCY) || (job == J_UY);
    case (job)
      J_STEPS: begin
        div_num = DW'({root, 1'b0});
        div_den = DW'(cs);
      end
      J_QX, J_QY: begin
        div_num = DW'(mag[axis]);
        div_den = n_steps;
      end
      J_QCX, J_QCY: begin
        div_num = DW'(qv[axis]);
        div_den = DW'(cs);
      end
      default: begin
        div_num = DW'(umag[axis]);
        div_den = DW'(cs);
      end
    endcase
  end

  assign div_sh = {div_r[DW-1:0], div_q[DW-1]};
  assign div_ge = div_sh >= {1'b0, div_d};
  assign rem_sh = {srem[33:0], sqv[65:64]};
  assign trial  = {root, 2'b01};

  // Bounds of the map in cells.
  always_comb begin
    lim_w = ({23'b0, map_w} > 32'(GRID_SIDE)) ? GW'(GRID_SIDE) : GW'(map_w);
    lim_h = ({23'b0, map_h} > 32'(GRID_SIDE)) ? GW'(GRID_SIDE) : GW'(map_h);
    out_of_map = (g[0] < 0) || (g[0] >= lim_w) || (g[1] < 0) || (g[1] >= lim_h);
  end

  // Step advance: offset remainder, then cell index and in-cell remainder.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      rsum[a]    = {1'b0, rr[a]} + {1'b0, rv[a]};
      e_c[a]     = rsum[a] >= {1'b0, n_steps};
      rr_next[a] = e_c[a] ? DW'(rsum[a] - {1'b0, n_steps}) : DW'(rsum[a]);
      if (!dd[a][32]) begin
        mt[a]      = {1'b0, mr[a]} + {1'b0, qm[a]} + (CSW+1)'(e_c[a]);
        mc[a]      = mt[a] >= {1'b0, cs};
        mr_next[a] = mc[a] ? CSW'(mt[a] - {1'b0, cs}) : CSW'(mt[a]);
        g_next[a]  = g[a] + $signed({2'b0, qc[a]}) + $signed(GW'(mc[a]));
      end else begin
        mt[a]      = {1'b0, mr[a]} - {1'b0, qm[a]} - (CSW+1)'(e_c[a]);
        mc[a]      = mt[a][CSW];
        mr_next[a] = mc[a] ? CSW'(mt[a] + {1'b0, cs}) : CSW'(mt[a]);
        g_next[a]  = g[a] - $signed({2'b0, qc[a]}) - $signed(GW'(mc[a]));
      end
    end
  end

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ld_row;
    mem_ra = ld_row;
    mem_wd = row_q;
    mem_wd[ld_col] = ld_bit;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = '0;
      end
      S_LDWR: begin
        mem_we = 1'b1;
      end
      S_CHK: begin
        mem_ra = g[1][AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_wa] <= mem_wd;
    end
    row_q <= grid_mem[mem_ra];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_w       <= '0;
      map_h       <= '0;
      org[0]      <= '0;
      org[1]      <= '0;
      cell_size_r <= CSW'(32'd1 << FRAC_BITS);
      thresh      <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_w       <= cfg_data[8:0];
        REG_MAP_HEIGHT: map_h       <= cfg_data[8:0];
        REG_ORIGIN_X:   org[0]      <= cfg_data;
        REG_ORIGIN_Y:   org[1]      <= cfg_data;
        REG_CELL_SIZE:  cell_size_r <= {1'b0, cfg_data[15:0]};
        REG_THRESHOLD:  thresh      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && m_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(GRID_SIDE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_fire) begin
            st[0]  <= s_tdata[31:0];
            st[1]  <= s_tdata[63:32];
            dd[0]  <= {s_tdata[95], s_tdata[95:64]} - {s_tdata[31], s_tdata[31:0]};
            dd[1]  <= {s_tdata[127], s_tdata[127:96]} - {s_tdata[63], s_tdata[63:32]};
            ld_col <= AW'({24'b0, s_tdata[135:128]});
            ld_row <= AW'({24'b0, s_tdata[143:136]});
            ld_bit <= $signed(s_tdata[151:144]) >= thresh;
            res    <= ST_FREE;
            cnt    <= '0;
            if (s_tuser == REQ_LOAD) begin
              if ((32'(s_tdata[135:128]) < 32'(GRID_SIDE)) &&
                  (32'(s_tdata[143:136]) < 32'(GRID_SIDE))) begin
                state <= S_LDRD;
              end else begin
                state <= S_DONE;
              end
            end else if (map_w == '0 || map_h == '0) begin
              state <= S_DONE;
            end else begin
              acc[0] <= '0;
              acc[1] <= '0;
              state  <= S_SQ;
            end
          end
        end
        S_LDRD: begin
          state <= S_LDWR;
        end
        S_LDWR: begin
          state <= S_DONE;
        end
        S_SQ: begin
          // Shift-add squaring of both axis spans, one bit per cycle.
          for (int a = 0; a < 2; a++) begin
            if (cnt == '0) begin
              sqa[a] <= {mag[a][31:0], 1'b0};
              acc[a] <= mag[a][32] ? 66'(mag[a]) : '0;
            end else begin
              sqa[a] <= {sqa[a][31:0], 1'b0};
              acc[a] <= {acc[a][64:0], 1'b0} + (sqa[a][32] ? 66'(mag[a]) : 66'd0);
            end
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd32) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          sqv   <= acc[0] + acc[1];
          root  <= '0;
          srem  <= '0;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          // Restoring square root, two radicand bits per cycle.
          sqv <= {sqv[63:0], 2'b00};
          if ({1'b0, rem_sh} >= {2'b0, trial}) begin
            srem <= 36'({1'b0, rem_sh} - {2'b0, trial});
            root <= {root[31:0], 1'b1};
          end else begin
            srem <= rem_sh;
            root <= {root[31:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd32) begin
            job   <= J_STEPS;
            state <= S_DLD;
          end
        end
        S_DLD: begin
          div_q <= div_num;
          div_d <= div_den;
          div_r <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          div_r <= div_ge ? (div_sh - {1'b0, div_d}) : div_sh;
          div_q <= {div_q[DW-2:0], div_ge};
          cnt   <= cnt + 6'd1;
          if (cnt == 6'(DW - 1)) begin
            state <= S_DIVE;
          end
        end
        S_DIVE: begin
          case (job)
            J_STEPS: begin
              n_steps <= (div_q == '0) ? DW'(1) : div_q;
            end
            J_QX, J_QY: begin
              qv[axis] <= div_q[32:0];
              rv[axis] <= div_r[DW-1:0];
            end
            J_QCX, J_QCY: begin
              qc[axis] <= div_q[32:0];
              qm[axis] <= div_r[CSW-1:0];
            end
            default: begin
              // Floor division of the start offset from the grid corner.
              if (u[axis][32] && div_r != '0) begin
                g[axis]  <= -$signed(GW'(div_q)) - $signed(GW'(1));
                mr[axis] <= cs - div_r[CSW-1:0];
              end else if (u[axis][32]) begin
                g[axis]  <= -$signed(GW'(div_q));
                mr[axis] <= '0;
              end else begin
                g[axis]  <= $signed(GW'(div_q));
                mr[axis] <= div_r[CSW-1:0];
              end
            end
          endcase
          if (job == J_UY) begin
            rr[0] <= '0;
            rr[1] <= '0;
            idx   <= '0;
            state <= S_CHK;
          end else begin
            job   <= job + 3'd1;
            state <= S_DLD;
          end
        end
        S_CHK: begin
          if (out_of_map) begin
            res   <= ST_OUT;
            state <= S_DONE;
          end else begin
            state <= S_TST;
          end
        end
        S_TST: begin
          if (row_q[g[0][AW-1:0]]) begin
            res   <= ST_HIT;
            state <= S_DONE;
          end else if (idx == n_steps) begin
            state <= S_DONE;
          end else begin
            for (int a = 0; a < 2; a++) begin
              rr[a] <= rr_next[a];
              mr[a] <= mr_next[a];
              g[a]  <= g_next[a];
            end
            idx   <= idx + DW'(1);
            state <= S_CHK;
          end
        end
        S_DONE: begin
          if (m_free) begin
            status_q <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // No request word is taken while the grid is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !s_tready)
    else $error("request accepted during grid clear");

  // The grid is written only by the clear sweep or a load write-back.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLR || state == S_LDWR))
    else $error("unexpected grid write");

  // A bit test always follows the bounds check that issued its row read.
  a_test_after_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_TST) |-> ($past(state) == S_CHK))
    else $error("grid bit tested without a fresh row read");

  // A delivered result is never the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_FREE || m_tdata[1:0] == ST_OUT ||
                  m_tdata[1:0] == ST_HIT))
    else $error("invalid status code");

endmodule : grid_segment_collision_check
`default_nettype wire

// ===== test/grid_segment_collision_check_tb.sv =====
// Self-checking testbench for the grid segment collision checker.
`timescale 1ns / 1ps
`default_nettype none
module grid_segment_collision_check_tb;
  import gsc_pkg::*;

  // The block is driven through its request stream and its register port.
  // Every accepted request word is run through a local model of the grid
  // and the segment walk, and the status it should produce is queued. The
  // result stream is checked in order against that queue.

  localparam int SIDE = GRID_SIDE_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_segment_collision_check DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the block's state: the grid bits and the six registers.
  bit grid_bits [SIDE*SIDE];
  logic [8:0] map_w, map_h;
  logic signed [31:0] org_x, org_y;
  logic [15:0] cell_sz;
  logic signed [7:0] occ_thresh;

  logic [1:0] status_due [$];
  int mismatches = 0;
  int loads_sent = 0, queries_sent = 0, results_seen = 0;
  int hits_seen = 0, outs_seen = 0, cfg_writes = 0;
  bit calm = 1'b0;
  bit failed = 1'b0;

  // Directed plan: register writes and request words, some with a status
  // known at a glance; a negative want means the model decides.
  typedef struct {
    bit is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0] val;
    logic req;
    longint xs, ys, xe, ye;
    int col, row, occ;
    int want;
  } plan_row_t;
  plan_row_t plan [$];

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  // Walks the segment sample by sample as the block does and returns the
  // status of the first sample that leaves the map or lands on an obstacle.
  function automatic logic [1:0] segment_status(longint xs, longint ys, longint xe, longint ye);
    longint w, h, cs, dx, dy, steps, cx, cy, gx, gy, ax, ay;
    logic [67:0] sq, root, trial;
    logic signed [95:0] prod, wide_i, wide_n;
    w = (map_w > SIDE) ? SIDE : map_w;
    h = (map_h > SIDE) ? SIDE : map_h;
    cs = (cell_sz == 0) ? 1 : cell_sz;
    if (w == 0 || h == 0) return ST_FREE;
    dx = xe - xs;
    dy = ye - ys;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (68'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    steps = (2 * longint'(root)) / cs;
    if (steps == 0) steps = 1;
    wide_n = steps;
    for (longint i = 0; i <= steps; i++) begin
      wide_i = i;
      prod = wide_i * 96'(signed'(dx));
      cx = xs + longint'(prod / wide_n);
      prod = wide_i * 96'(signed'(dy));
      cy = ys + longint'(prod / wide_n);
      gx = floor_div(cx - longint'(org_x), cs);
      gy = floor_div(cy - longint'(org_y), cs);
      if (gx < 0 || gx >= w || gy < 0 || gy >= h) return ST_OUT;
      if (grid_bits[gy * SIDE + gx]) return ST_HIT;
    end
    return ST_FREE;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    plan_row_t r;
    r = '{default: 0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    plan = {plan, r};
  endfunction

  function automatic void add_word(logic req, longint xs, longint ys, longint xe, longint ye,
                                   int col, int row, int occ, int want);
    plan_row_t r;
    r = '{default: 0};
    r.req = req;
    r.xs = xs; r.ys = ys; r.xe = xe; r.ye = ye;
    r.col = col; r.row = row; r.occ = occ;
    r.want = want;
    plan = {plan, r};
  endfunction

  // Registers are only written once every result is back, plus a margin.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_MAP_WIDTH:  map_w = val[8:0];
      REG_MAP_HEIGHT: map_h = val[8:0];
      REG_ORIGIN_X:   org_x = val;
      REG_ORIGIN_Y:   org_y = val;
      REG_CELL_SIZE:  cell_sz = val[15:0];
      REG_THRESHOLD:  occ_thresh = val[7:0];
      default: ;
    endcase
  endtask

  // Sends one request word, then books its expected status at acceptance.
  task automatic send_word(logic req, longint xs, longint ys, longint xe, longint ye,
                           int col, int row, int occ, int want);
    logic [1:0] st;
    logic signed [7:0] occ8;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {8'(occ), 8'(row), 8'(col), 32'(ye), 32'(xe), 32'(ys), 32'(xs)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (req == REQ_LOAD) begin
      occ8 = 8'(occ);
      grid_bits[(row & 255) * SIDE + (col & 255)] = (occ8 >= occ_thresh);
      st = ST_FREE;
      loads_sent++;
    end else begin
      st = segment_status(xs, ys, xe, ye);
      queries_sent++;
    end
    if (want >= 0) st = 2'(want);
    status_due = {status_due, st};
  endtask

  // Random query, mostly aimed at the current map in cell units, so walks stay short.
  task automatic random_query();
    longint cs, w, h, gxs, gys, gxe, gye, xs, ys, xe, ye;
    int span;
    cs = (cell_sz == 0) ? 1 : cell_sz;
    w = (map_w > SIDE) ? SIDE : map_w;
    h = (map_h > SIDE) ? SIDE : map_h;
    if ($urandom_range(0, 19) == 0) begin
      send_word(REQ_QUERY, longint'($signed($urandom)), longint'($signed($urandom)),
                longint'($signed($urandom)), longint'($signed($urandom)),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), -1);
    end else begin
      gxs = longint'($urandom_range(0, w + 3)) - 2;
      gys = longint'($urandom_range(0, h + 3)) - 2;
      span = ($urandom_range(0, 6) == 0) ? 300 : 6;
      gxe = gxs + longint'($urandom_range(0, 2 * span)) - span;
      gye = gys + longint'($urandom_range(0, 2 * span)) - span;
      if ($urandom_range(0, 9) == 0) begin
        gxe = gxs;
        gye = gys;
      end
      xs = clamp32(longint'(org_x) + gxs * cs + longint'($urandom_range(0, cs - 1)));
      ys = clamp32(longint'(org_y) + gys * cs + longint'($urandom_range(0, cs - 1)));
      xe = ($urandom_range(0, 9) == 0 && gxe == gxs && gye == gys) ? xs :
           clamp32(longint'(org_x) + gxe * cs + longint'($urandom_range(0, cs - 1)));
      ye = (xe == xs && gxe == gxs && gye == gys) ? ys :
           clamp32(longint'(org_y) + gye * cs + longint'($urandom_range(0, cs - 1)));
      send_word(REQ_QUERY, xs, ys, xe, ye,
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), -1);
    end
  endtask

  // Result side: stalls come in random bursts until the calm tail.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) m_tready <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(1, 11);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Every status word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tdata[1:0] == ST_HIT) hits_seen++;
      if (m_tdata[1:0] == ST_OUT) outs_seen++;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: status %0d arrived with nothing expected", m_tdata[1:0]);
      end else begin
        if (m_tdata[1:0] !== status_due[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d status expected %0d got %0d",
                     results_seen, status_due[0], m_tdata[1:0]);
        end
        void'(status_due.pop_front());
      end
    end
  end

  // The watchdog counts cycles with no word moving on any channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d results still outstanding", status_due.size());
      $display("grid_segment_collision_check_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int w_sel, h_sel, wait_cycles;
    logic [31:0] ox, oy, cs_sel;
    foreach (grid_bits[k]) grid_bits[k] = 1'b0;
    map_w = 0; map_h = 0; org_x = 0; org_y = 0;
    cell_sz = 16'd1 << FRAC_BITS_DEF;
    occ_thresh = THRESH_RESET;

    // Directed plan. After reset the map is empty, so every query is free.
    add_word(REQ_QUERY, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
             64'sd2147483647, 255, 255, 255, ST_FREE);
    add_cfg(REG_MAP_WIDTH, 32'd511);   // above the grid side, acts as full
    add_cfg(REG_MAP_HEIGHT, 32'd16);
    add_cfg(REG_ORIGIN_X, 32'd0);
    add_cfg(REG_ORIGIN_Y, 32'd0);
    add_cfg(REG_CELL_SIZE, 32'd256);
    add_cfg(REG_THRESHOLD, 32'd50);
    add_word(REQ_LOAD, 0, 0, 0, 0, 0, 0, 127, ST_FREE);
    add_word(REQ_LOAD, -1, -1, -1, -1, 255, 255, -128, ST_FREE);
    add_word(REQ_LOAD, 0, 0, 0, 0, 3, 3, 50, ST_FREE);   // equal to threshold: occupied
    add_word(REQ_LOAD, 0, 0, 0, 0, 4, 3, 49, ST_FREE);   // just below: free
    add_word(REQ_QUERY, 128, 128, 640, 128, 0, 0, 0, ST_HIT);
    add_word(REQ_QUERY, -1, 512, 1024, 512, 0, 0, 0, ST_OUT);
    add_word(REQ_QUERY, 896, 2600, 896, 896, 0, 0, 0, -1);
    add_word(REQ_QUERY, 896, 896, 896, 896, 0, 0, 0, ST_HIT);   // zero length
    add_word(REQ_QUERY, 1152, 896, 1152, 896, 0, 0, 0, ST_FREE);
    add_word(REQ_QUERY, 64'sd2147483647, 64'sd2147483647, 0, 0, 0, 0, 0, ST_OUT);
    add_word(REQ_QUERY, 300, 2000, 76800, 2000, 0, 0, 0, -1);   // runs off the right side
    add_cfg(REG_CELL_SIZE, 32'd0);     // zero cell size acts as one
    add_word(REQ_QUERY, 1, 1, 40, 9, 0, 0, 0, -1);
    add_cfg(REG_CELL_SIZE, 32'd65535);
    add_word(REQ_QUERY, 70000, 70000, 900000, 800000, 0, 0, 0, -1);
    add_cfg(REG_THRESHOLD, 32'hFFFF_FF80);
    add_word(REQ_LOAD, 0, 0, 0, 0, 5, 5, -128, -1);
    add_cfg(REG_THRESHOLD, 32'd127);
    add_word(REQ_LOAD, 0, 0, 0, 0, 6, 6, 127, -1);
    add_word(REQ_LOAD, 0, 0, 0, 0, 0, 0, 126, -1);
    add_cfg(REG_ORIGIN_X, 32'h8000_0000);
    add_cfg(REG_ORIGIN_Y, 32'h7FFF_FF00);
    add_word(REQ_QUERY, -64'sd2147483648, 64'sd2147483647, -64'sd2147483000,
             64'sd2147483647, 0, 0, 0, -1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_cfg)
        write_reg(plan[k].idx, plan[k].val);
      else
        send_word(plan[k].req, plan[k].xs, plan[k].ys, plan[k].xe, plan[k].ye,
                  plan[k].col, plan[k].row, plan[k].occ, plan[k].want);
    end

    // Random phases, each with its own register setting. The last one runs
    // with no idling on either side.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin w_sel = 256; h_sel = 256; cs_sel = 256; ox = 0; oy = 0; end
        1: begin w_sel = 1; h_sel = 1; cs_sel = 1; ox = 32'hFFFF_FF00; oy = 5; end
        2: begin w_sel = 511; h_sel = 300; cs_sel = 65535; ox = 32'h8000_0000;
                 oy = 32'hC000_0000; end
        3: begin w_sel = 0; h_sel = 200; cs_sel = 300; ox = 0; oy = 0; end
        4: begin w_sel = 37; h_sel = 19; cs_sel = 0; ox = 32'h7FFF_FFFF; oy = 12; end
        default: begin
          w_sel = $urandom_range(0, 300);
          h_sel = $urandom_range(1, 300);
          cs_sel = $urandom_range(1, 65535);
          ox = $signed($urandom_range(0, 2000000)) - 1000000;
          oy = $signed($urandom_range(0, 2000000)) - 1000000;
        end
      endcase
      if (ph == 9) calm = 1'b1;
      write_reg(REG_MAP_WIDTH, w_sel);
      write_reg(REG_MAP_HEIGHT, h_sel);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_CELL_SIZE, cs_sel);
      write_reg(REG_THRESHOLD, $urandom_range(0, 255));
      for (int n = 0; n < 160; n++) begin
        if ($urandom_range(0, 9) < 4) begin
          send_word(REQ_LOAD, longint'($signed($urandom)), longint'($signed($urandom)),
                    longint'($signed($urandom)), longint'($signed($urandom)),
                    ($urandom_range(0, 3) == 0 || w_sel == 0) ? $urandom_range(0, 255)
                      : $urandom_range(0, (w_sel > 256 ? 256 : w_sel) - 1),
                    $urandom_range(0, (h_sel > 256 ? 256 : h_sel) - 1),
                    $urandom_range(0, 255), -1);
        end else begin
          random_query();
        end
      end
    end

    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    wait_cycles = 40;
    repeat (wait_cycles) @(posedge clk);
    if (mismatches != 0) failed = 1'b1;

    $display("Covered %0d loads and %0d segment queries over %0d register writes;",
             loads_sent, queries_sent, cfg_writes);
    $display("%0d results checked, %0d hit an obstacle, %0d left the map, %0d mismatches.",
             results_seen, hits_seen, outs_seen, mismatches);
    if (!failed) begin
      $display("grid_segment_collision_check_tb: done, clean");
    end else begin
      $display("grid_segment_collision_check_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/gsc_pkg.sv
design/grid_segment_collision_check.sv
test/grid_segment_collision_check_tb.sv
